[design/fbc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants of the feathered box compositor
// Register map codes, pipeline stage payloads and the fixed-point
// constants of the alpha divider and the Q2.14 blend.
// ----------------------------------------------------------------------------
package fbc_pkg;

  // Register map, word index (byte address / 4)
  typedef enum logic [2:0] {
    REG_BOX_X   = 3'd0,
    REG_BOX_Y   = 3'd1,
    REG_BOX_W   = 3'd2,
    REG_BOX_H   = 3'd3,
    REG_FEATHER = 3'd4
  } reg_idx_e;

  // Pipeline layout
  localparam int unsigned NUM_STAGES = 16;
  localparam int unsigned DIV_STEPS  = 8;   // two quotient bits per step
  localparam int unsigned STG_DIV0   = 2;   // divider seed stage
  localparam int unsigned STG_ALPHA  = STG_DIV0 + DIV_STEPS + 1;
  localparam int unsigned STG_MUL    = STG_ALPHA + 1;
  localparam int unsigned STG_SUM    = STG_MUL + 1;
  localparam int unsigned STG_RECIP  = STG_SUM + 1;
  localparam int unsigned STG_OUT    = STG_RECIP + 1;

  // Alpha of one in Q1.16
  localparam logic [16:0] ALPHA_ONE = 17'd65536;

  // Blend bias: half of 65536*255 plus 255*32768 scaled by 65536, which keeps
  // the shifted sum non-negative before the divide by 255
  localparam logic [43:0] BLEND_BIAS = 44'd547616686080;

  // floor(2^24 / 255): the estimate is low by at most one
  localparam logic [16:0] RECIP_255 = 17'd65793;
  localparam logic [23:0] DIV_255   = 24'd255;

  // One channel in flight: e = 255*gen - 16384*orig
  typedef struct packed {
    logic [7:0]  orig;
    logic [24:0] e;
  } chan_t;

  // Box test results
  typedef struct packed {
    logic        in_box;
    logic [12:0] dx_lo;
    logic [13:0] dx_hi;
    logic [12:0] dy_lo;
    logic [13:0] dy_hi;
    chan_t [2:0] ch;
  } box_t;

  // Edge distance
  typedef struct packed {
    logic        in_box;
    logic [12:0] min_dist;
    chan_t [2:0] ch;
  } dist_t;

  // Divider state
  typedef struct packed {
    logic        in_box;
    logic        clamp;
    logic [14:0] rem;
    logic [15:0] quo;
    chan_t [2:0] ch;
  } div_t;

  typedef struct packed {
    logic [16:0] alpha;
    chan_t [2:0] ch;
  } alpha_t;

  typedef struct packed {
    logic [16:0]       alpha;
    logic [2:0][7:0]   orig;
    logic [2:0][42:0]  prod;
  } mul_t;

  typedef struct packed {
    logic [16:0]      alpha;
    logic [2:0][23:0] z;
  } sum_t;

  typedef struct packed {
    logic [16:0]      alpha;
    logic [2:0][23:0] z;
    logic [2:0][15:0] qa;
  } recip_t;

  typedef struct packed {
    logic [16:0]      alpha;
    logic [2:0][15:0] pix;
  } res_t;

  // One restoring division step: returns {next remainder, quotient bit}
  function automatic logic [15:0] div_step(logic [14:0] rem, logic nbit,
                                           logic [14:0] den);
    logic [15:0] t;
    logic [15:0] diff;
    t    = {rem, nbit};
    diff = t - {1'b0, den};
    if (t >= {1'b0, den}) begin
      return {diff[14:0], 1'b1};
    end else begin
      return {t[14:0], 1'b0};
    end
  endfunction

endpackage

[design/feathered_box_composite.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// feathered_box_composite: feathered rectangle alpha blend
// Per pixel alpha from a configured box and feather ramp, then blend of the
// generated Q2.14 channels over the original bytes.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per beat (coordinates, original bytes, generated
//   Q2.14 channels). m_axis returns one composited beat per input beat, in
//   order, with the alpha that was applied.
//   The APB port holds the box corner, box size and feather span. Write it
//   only while no pixel is in flight; pready is always high.
// Timing:
//   One pixel is taken per cycle while the output is not stalled. The depth
//   is set by the alpha divider, 16 quotient bits over eight stages,
//   followed by the blend multiply and the divide by 255.
// Reset:
//   Registers return to box (0,0) of size 1x1 with hard edges, and all
//   pipeline stages are emptied.
// Stall:
//   Each stage holds its beat while the next one is full and blocked, so
//   empty stages keep filling and s_axis_tready drops only once every stage
//   holds a beat. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module feathered_box_composite (
  input  logic         clk_i,
  input  logic         rst_ni,
  // pixel in: pix_x, pix_y, orig_red, orig_green, orig_blue,
  //           gen_red, gen_green, gen_blue, zero pad to 104 bits
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [103:0] s_axis_tdata,
  // result out: out_red, out_green, out_blue, blend_weight,
  //             zero pad to 72 bits
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,
  // configuration
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned NS = fbc_pkg::NUM_STAGES;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [12:0] box_x_q, box_y_q;
  logic [13:0] box_w_q, box_h_q, feather_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_x_q   <= 13'd0;
      box_y_q   <= 13'd0;
      box_w_q   <= 14'd1;
      box_h_q   <= 14'd1;
      feather_q <= 14'd0;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        fbc_pkg::REG_BOX_X:   box_x_q   <= pwdata[12:0];
        fbc_pkg::REG_BOX_Y:   box_y_q   <= pwdata[12:0];
        fbc_pkg::REG_BOX_W:   box_w_q   <= pwdata[13:0];
        fbc_pkg::REG_BOX_H:   box_h_q   <= pwdata[13:0];
        fbc_pkg::REG_FEATHER: feather_q <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      fbc_pkg::REG_BOX_X:   prdata = {19'd0, box_x_q};
      fbc_pkg::REG_BOX_Y:   prdata = {19'd0, box_y_q};
      fbc_pkg::REG_BOX_W:   prdata = {18'd0, box_w_q};
      fbc_pkg::REG_BOX_H:   prdata = {18'd0, box_h_q};
      fbc_pkg::REG_FEATHER: prdata = {18'd0, feather_q};
      default:              prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or the next one loads
  // --------------------------------------------------------------------------
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = ~vld_q[NS-1] | m_axis_tready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign s_axis_tready = en[0];

  // --------------------------------------------------------------------------
  // Stage 0: box test, edge distances, channel prescale
  // --------------------------------------------------------------------------
  logic [12:0]  pix_x, pix_y;
  logic [14:0]  right, bottom;
  logic [14:0]  dx_hi_w, dy_hi_w;
  fbc_pkg::box_t box_d, box_q;

  assign pix_x   = s_axis_tdata[12:0];
  assign pix_y   = s_axis_tdata[25:13];
  assign right   = {2'b00, box_x_q} + {1'b0, box_w_q};
  assign bottom  = {2'b00, box_y_q} + {1'b0, box_h_q};
  assign dx_hi_w = right - 15'd1 - {2'b00, pix_x};
  assign dy_hi_w = bottom - 15'd1 - {2'b00, pix_y};

  always_comb begin
    logic [15:0] gen;
    logic [7:0]  orig;
    logic [24:0] gx;
    box_d.in_box = (pix_x >= box_x_q) && ({2'b00, pix_x} < right) &&
                   (pix_y >= box_y_q) && ({2'b00, pix_y} < bottom);
    box_d.dx_lo  = pix_x - box_x_q;
    box_d.dx_hi  = dx_hi_w[13:0];
    box_d.dy_lo  = pix_y - box_y_q;
    box_d.dy_hi  = dy_hi_w[13:0];
    // e = 255*gen - 16384*orig
    for (int c = 0; c < 3; c++) begin
      orig = s_axis_tdata[26 + 8*c +: 8];
      gen  = s_axis_tdata[50 + 16*c +: 16];
      gx   = {{9{gen[15]}}, gen};
      box_d.ch[c].orig = orig;
      box_d.ch[c].e    = {gx[16:0], 8'd0} - gx - {3'd0, orig, 14'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) box_q <= box_d;
  end

  // --------------------------------------------------------------------------
  // Stage 1: nearest edge distance
  // --------------------------------------------------------------------------
  fbc_pkg::dist_t dist_d, dist_q;

  always_comb begin
    logic [13:0] mx, my, mm;
    mx = ({1'b0, box_q.dx_lo} < box_q.dx_hi) ? {1'b0, box_q.dx_lo} : box_q.dx_hi;
    my = ({1'b0, box_q.dy_lo} < box_q.dy_hi) ? {1'b0, box_q.dy_lo} : box_q.dy_hi;
    mm = (mx < my) ? mx : my;
    dist_d.in_box   = box_q.in_box;
    dist_d.min_dist = mm[12:0];
    dist_d.ch       = box_q.ch;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) dist_q <= dist_d;
  end

  // --------------------------------------------------------------------------
  // Stages 2..10: alpha = ((2d+1)*65536 + f) / (2f), restoring divider.
  // The dividend's upper part is {d,1}, its low 16 bits are f. If the upper
  // part reaches the divisor the quotient is at least one and alpha clamps;
  // a zero feather clamps the same way.
  // --------------------------------------------------------------------------
  logic [14:0]   den;
  logic [15:0]   num_lo;
  fbc_pkg::div_t div_q [fbc_pkg::DIV_STEPS+1];

  assign den    = {feather_q, 1'b0};
  assign num_lo = {2'b00, feather_q};

  always_ff @(posedge clk_i) begin
    if (en[fbc_pkg::STG_DIV0]) begin
      div_q[0].in_box <= dist_q.in_box;
      div_q[0].clamp  <= ({1'b0, dist_q.min_dist, 1'b1} >= den);
      div_q[0].rem    <= {1'b0, dist_q.min_dist, 1'b1};
      div_q[0].quo    <= 16'd0;
      div_q[0].ch     <= dist_q.ch;
    end
  end

  for (genvar i = 1; i <= fbc_pkg::DIV_STEPS; i++) begin : g_div
    logic [15:0]   s1, s2;
    fbc_pkg::div_t nxt;

    always_comb begin
      s1  = fbc_pkg::div_step(div_q[i-1].rem, num_lo[17-2*i], den);
      s2  = fbc_pkg::div_step(s1[15:1], num_lo[16-2*i], den);
      nxt = div_q[i-1];
      nxt.rem = s2[15:1];
      nxt.quo = {div_q[i-1].quo[13:0], s1[0], s2[0]};
    end

    always_ff @(posedge clk_i) begin
      if (en[fbc_pkg::STG_DIV0 + i]) div_q[i] <= nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 11: select alpha
  // --------------------------------------------------------------------------
  fbc_pkg::alpha_t alpha_q;

  always_ff @(posedge clk_i) begin
    if (en[fbc_pkg::STG_ALPHA]) begin
      if (!div_q[fbc_pkg::DIV_STEPS].in_box) begin
        alpha_q.alpha <= 17'd0;
      end else if (div_q[fbc_pkg::DIV_STEPS].clamp) begin
        alpha_q.alpha <= fbc_pkg::ALPHA_ONE;
      end else begin
        alpha_q.alpha <= {1'b0, div_q[fbc_pkg::DIV_STEPS].quo};
      end
      alpha_q.ch <= div_q[fbc_pkg::DIV_STEPS].ch;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 12: alpha * (255*gen - 16384*orig)
  // --------------------------------------------------------------------------
  fbc_pkg::mul_t mul_d, mul_q;

  always_comb begin
    logic signed [42:0] p;
    mul_d.alpha = alpha_q.alpha;
    for (int c = 0; c < 3; c++) begin
      p = $signed({1'b0, alpha_q.alpha}) * $signed(alpha_q.ch[c].e);
      mul_d.orig[c] = alpha_q.ch[c].orig;
      mul_d.prod[c] = p;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[fbc_pkg::STG_MUL]) mul_q <= mul_d;
  end

  // --------------------------------------------------------------------------
  // Stage 13: add orig*2^30 and the bias, drop 16 fraction bits
  // --------------------------------------------------------------------------
  fbc_pkg::sum_t sum_d, sum_q;

  always_comb begin
    logic [43:0] s;
    sum_d.alpha = mul_q.alpha;
    for (int c = 0; c < 3; c++) begin
      s = {mul_q.prod[c][42], mul_q.prod[c]} + {6'd0, mul_q.orig[c], 30'd0} +
          fbc_pkg::BLEND_BIAS;
      sum_d.z[c] = s[39:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[fbc_pkg::STG_SUM]) sum_q <= sum_d;
  end

  // --------------------------------------------------------------------------
  // Stage 14: quotient estimate of z/255 by reciprocal
  // --------------------------------------------------------------------------
  fbc_pkg::recip_t rcp_d, rcp_q;

  always_comb begin
    logic [40:0] m;
    rcp_d.alpha = sum_q.alpha;
    rcp_d.z     = sum_q.z;
    for (int c = 0; c < 3; c++) begin
      m = {17'd0, sum_q.z[c]} * {24'd0, fbc_pkg::RECIP_255};
      rcp_d.qa[c] = m[39:24];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[fbc_pkg::STG_RECIP]) rcp_q <= rcp_d;
  end

  // --------------------------------------------------------------------------
  // Stage 15: correct the estimate, remove the offset of 32768
  // --------------------------------------------------------------------------
  fbc_pkg::res_t res_d, res_q;

  always_comb begin
    logic [23:0] m255, r;
    logic [15:0] q;
    res_d.alpha = rcp_q.alpha;
    for (int c = 0; c < 3; c++) begin
      m255 = {rcp_q.qa[c], 8'd0} - {8'd0, rcp_q.qa[c]};
      r    = rcp_q.z[c] - m255;
      q    = rcp_q.qa[c] + {15'd0, (r >= fbc_pkg::DIV_255)};
      res_d.pix[c] = {~q[15], q[14:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[fbc_pkg::STG_OUT]) res_q <= res_d;
  end

  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata  = {7'd0, res_q.alpha, res_q.pix[2], res_q.pix[1], res_q.pix[0]};

endmodule
